[hw/rtl/sdiv_pkg.sv]
package sdiv_pkg;

  // Operand width of the divider core; port fields stay DATA_W wide.
  localparam int unsigned DATA_W = 64;
  localparam int unsigned WIDTH  = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] dividend;
    logic signed [DATA_W-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quotient;
    logic signed [DATA_W-1:0] remainder_out;
    logic                     divide_by_zero;
  } out_t;

  // Partial remainder, dividend bits still to consume (upper) with quotient
  // bits shifted in (lower), divisor magnitude, and the sign bookkeeping.
  typedef struct packed {
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] num_quo;
    logic [WIDTH-1:0] den;
    logic             num_neg;
    logic             quo_neg;
    logic             den_zero;
  } stage_t;

endpackage

[hw/rtl/sdiv_step.sv]
module sdiv_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  sdiv_pkg::stage_t data_i,
  output logic            valid_o,
  output sdiv_pkg::stage_t data_o
);

  logic [sdiv_pkg::WIDTH-1:0] rem_sh;
  logic                       fits;
  sdiv_pkg::stage_t           data_d;
  sdiv_pkg::stage_t           data_q;
  logic                       valid_q;

  // Bring down the next dividend bit, then try the subtraction.
  assign rem_sh = {data_i.rem[sdiv_pkg::WIDTH-2:0], data_i.num_quo[sdiv_pkg::WIDTH-1]};
  assign fits   = (rem_sh >= data_i.den);

  always_comb begin
    data_d         = data_i;
    data_d.rem     = fits ? (rem_sh - data_i.den) : rem_sh;
    data_d.num_quo = {data_i.num_quo[sdiv_pkg::WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/signed_truncating_divider.sv]
// The operand register loads at the transfer edge, then each quotient bit has its own step
//   register, and the sign stage feeds the output register.
// Throughput: one transfer per cycle unless held; the restoring chain sets the latency.
// The whole pipeline holds, bubbles included, only when the last stage carries an item
//   and the output register is full and not taken.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers keep no reset.
module signed_truncating_divider (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sdiv_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sdiv_pkg::out_t out_o
);

  localparam int unsigned W = sdiv_pkg::WIDTH;

  // Stage 0 is the operand register, stages 1..W follow each quotient bit.
  sdiv_pkg::stage_t stage_data [0:W];
  logic             stage_valid [0:W];

  logic             pipe_en;
  logic             out_load;

  logic [W-1:0]     num_raw;
  logic [W-1:0]     den_raw;
  logic             num_neg;
  logic             den_neg;
  sdiv_pkg::stage_t in_stage;
  sdiv_pkg::stage_t s0_data_q;
  logic             s0_valid_q;

  sdiv_pkg::stage_t last;
  logic [W-1:0]     quo_mag;
  logic signed [W-1:0] quo_fin;
  logic signed [W-1:0] rem_fin;
  sdiv_pkg::out_t   out_d;
  sdiv_pkg::out_t   out_q;
  logic             out_valid_q;

  // Hold everything only when the last stage cannot hand off its item.
  assign pipe_en    = !(stage_valid[W] && out_valid_q && !out_ready_i);
  assign in_ready_o = pipe_en;

  // Operand stage: drop the bits above WIDTH and reduce both operands to magnitudes.
  assign num_raw = in_i.dividend[W-1:0];
  assign den_raw = in_i.divisor[W-1:0];
  assign num_neg = num_raw[W-1];
  assign den_neg = den_raw[W-1];

  always_comb begin
    in_stage          = '0;
    in_stage.num_quo  = num_neg ? (~num_raw + W'(1)) : num_raw;
    in_stage.den      = den_neg ? (~den_raw + W'(1)) : den_raw;
    in_stage.num_neg  = num_neg;
    in_stage.quo_neg  = num_neg ^ den_neg;
    in_stage.den_zero = (den_raw == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && in_valid_i) begin
      s0_data_q <= in_stage;
    end
  end

  assign stage_data[0]  = s0_data_q;
  assign stage_valid[0] = s0_valid_q;

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < W; k++) begin : g_step
    sdiv_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (stage_valid[k]),
      .data_i  (stage_data[k]),
      .valid_o (stage_valid[k+1]),
      .data_o  (stage_data[k+1])
    );
  end

  // Sign stage: negate the quotient when the signs differ, give the remainder the
  // dividend's sign. Most negative over minus one wraps back to itself here.
  assign last    = stage_data[W];
  assign quo_mag = last.num_quo;
  assign quo_fin = last.quo_neg ? signed'(~quo_mag + W'(1)) : signed'(quo_mag);
  assign rem_fin = last.num_neg ? signed'(~last.rem + W'(1)) : signed'(last.rem);

  always_comb begin
    out_d.quotient       = sdiv_pkg::DATA_W'(quo_fin);
    out_d.remainder_out  = sdiv_pkg::DATA_W'(rem_fin);
    out_d.divide_by_zero = last.den_zero;
  end

  // Load the output register when it is empty or being drained.
  assign out_load = stage_valid[W] && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A transfer in always lands in the operand stage.
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s0_valid_q)
    else $error("accepted operands did not reach the operand stage");

  // Back-pressure only comes from a full, untaken output register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && stage_valid[W])
    else $error("input stalled without a blocked output");

  // A stalled last-stage item is neither lost nor altered.
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid[W] && !pipe_en |=> stage_valid[W] && $stable(stage_data[W]))
    else $error("last stage item changed during a stall");

  // A zero divisor leaves a quotient of plus or minus one.
  a_dz_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.divide_by_zero |->
      (out_o.quotient == 64'sd1) || (out_o.quotient == -64'sd1))
    else $error("zero-divisor quotient is not plus or minus one");

endmodule
